[rtl/rctdma_pkg.sv]
// Shared types and constants for the rod conduction tridiagonal solver.
`default_nettype none
package rctdma_pkg;
    localparam int unsigned TempW  = 32;
    localparam int unsigned CountW = 5;
    localparam logic signed [31:0] FxOne   = 32'sh0001_0000;
    localparam logic signed [31:0] FxTwo   = 32'sh0002_0000;
    localparam logic signed [31:0] FxThree = 32'sh0003_0000;

    // One queued request between front and back.
    typedef struct packed {
        logic signed [31:0] left_temp;
        logic signed [31:0] right_temp;
        logic [4:0]         node_count;
    } req_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

[rtl/rctdma_divider.sv]
// Serial Q16.16 divider: (num << 16) / den, truncated toward zero, one bit a cycle.
`default_nettype none
module rctdma_divider (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [63:0]      quot
);
    // num magnitude fits 50 bits, shifted it fits 66; use 80-bit dividend
    localparam int unsigned DivW = 80;
    localparam int unsigned CntW = 7;

    logic [DivW-1:0] dvd_reg, dvd_next;
    logic [DivW-1:0] q_reg, q_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     den_reg, den_next;
    logic            neg_reg, neg_next;
    logic            zero_reg, zero_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [63:0]     mag;
    logic [33:0]     trial;

    assign mag   = num[63] ? 64'(-num) : 64'(num);
    assign trial = {rem_reg, dvd_reg[DivW-1]} - {2'b00, den_reg};

    // Restoring division step
    always_comb begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            dvd_next  = {mag, 16'd0};
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[63];
            zero_next = (den <= 0);
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_next = trial[32:0];
                q_next   = {q_reg[DivW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], dvd_reg[DivW-1]};
                q_next   = {q_reg[DivW-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[DivW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DivW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quot = zero_reg ? 64'sd0 :
                  (neg_reg ? -$signed(q_reg[63:0]) : $signed(q_reg[63:0]));
endmodule
`default_nettype wire

[rtl/rctdma_front.sv]
// Front end: accepts requests, clamps node count, drops empty ones, queues them.
`default_nettype none
module rctdma_front #(
    parameter int unsigned MAX_NODES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rctdma_pkg::req_t     in_req,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output rctdma_pkg::req_t          q_req
);
    localparam int unsigned Depth = 2;

    rctdma_pkg::req_t buf_reg [Depth];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    rctdma_pkg::req_t cls;
    logic       push, pop;

    // Clamp count to MAX_NODES
    always_comb begin
        cls = in_req;
        if (32'(in_req.node_count) > MAX_NODES) begin
            cls.node_count = 5'(MAX_NODES);
        end
    end

    assign in_ready = (cnt_reg != 2'(Depth));
    assign push     = in_valid && in_ready && (in_req.node_count != '0);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_req    = buf_reg[rp_reg];

    // Advance queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) buf_reg[wp_reg] <= cls;
    end
endmodule
`default_nettype wire

[rtl/rctdma_back.sv]
// Back end: forward sweep, back substitution and node output sequencer.
`default_nettype none
module rctdma_back #(
    parameter int unsigned MAX_NODES = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire rctdma_pkg::req_t  q_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [4:0]             m_index,
    output logic signed [31:0]     m_temp,
    output logic                   m_last
);
    // The node count is 5 bits wide, so no request uses more than 31 rows
    localparam int unsigned Rows = (MAX_NODES < 31) ? MAX_NODES : 31;
    localparam int unsigned IdxW = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int unsigned CntW = $clog2(Rows + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_F_RHS, ST_F_RHSW, ST_F_PIV, ST_F_PIVW, ST_F_RHS2, ST_F_RHS2W,
        ST_B_INIT, ST_B_DIV, ST_B_DIVW, ST_O_OUT
    } state_t;

    logic signed [31:0] piv_mem [Rows];
    logic signed [31:0] rhs_mem [Rows];
    logic signed [31:0] sol_mem [Rows];

    state_t             st_reg;
    logic [CntW-1:0]    n_reg, i_reg;
    logic signed [31:0] ua_reg, ub_reg;
    logic signed [31:0] prev_piv_reg, prev_rhs_reg, cur_piv_reg, x_reg;
    logic               m_valid_reg, m_last_reg;
    logic [4:0]         m_index_reg;
    logic signed [31:0] m_temp_reg;

    logic               div_start;
    logic signed [63:0] div_num;
    logic signed [31:0] div_den;
    logic               div_done;
    logic signed [63:0] div_q;

    rctdma_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quot(div_q)
    );

    logic               is_last_row;
    logic signed [63:0] piv_full;
    logic signed [31:0] q_sat;
    logic signed [31:0] piv_sat;
    logic signed [31:0] back_val;
    assign is_last_row = (i_reg == n_reg - 1'b1);
    assign piv_full = (is_last_row ? 64'(rctdma_pkg::FxThree) : 64'(rctdma_pkg::FxTwo))
                      - div_q;
    assign q_sat    = rctdma_pkg::sat32(div_q);
    assign piv_sat  = rctdma_pkg::sat32(piv_full);
    assign back_val = rctdma_pkg::sat32(64'(rhs_mem[IdxW'(i_reg - 1'b1)]) + div_q);

    // Divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = cur_piv_reg;
        case (st_reg)
            ST_F_RHS: begin
                div_start = 1'b1;
                div_num   = (n_reg == CntW'(1)) ? 64'(ub_reg) <<< 1 : 64'(ua_reg) <<< 1;
                div_den   = rctdma_pkg::FxThree;
            end
            ST_F_PIV: begin
                div_start = 1'b1;
                div_num   = 64'(rctdma_pkg::FxOne);
                div_den   = prev_piv_reg;
            end
            ST_F_RHS2: begin
                div_start = 1'b1;
                div_num   = (is_last_row ? 64'(ub_reg) <<< 1 : 64'sd0)
                            + 64'(prev_rhs_reg);
                div_den   = cur_piv_reg;
            end
            ST_B_DIV: begin
                div_start = 1'b1;
                div_num   = 64'(x_reg);
                div_den   = piv_mem[IdxW'(i_reg - 1'b1)];
            end
            default: ;
        endcase
    end

    assign q_ready = (st_reg == ST_IDLE);

    // Hold state, step the sweeps, drive outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            n_reg       <= '0;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        ua_reg <= q_req.left_temp;
                        ub_reg <= q_req.right_temp;
                        n_reg  <= CntW'(q_req.node_count);
                        i_reg  <= '0;
                        st_reg <= ST_F_RHS;
                    end
                end
                ST_F_RHS: st_reg <= ST_F_RHSW;
                ST_F_RHSW: begin
                    if (div_done) begin
                        piv_mem[0]   <= rctdma_pkg::FxThree;
                        rhs_mem[0]   <= q_sat;
                        prev_piv_reg <= rctdma_pkg::FxThree;
                        prev_rhs_reg <= q_sat;
                        i_reg        <= CntW'(1);
                        st_reg       <= (n_reg == CntW'(1)) ? ST_B_INIT : ST_F_PIV;
                    end
                end
                ST_F_PIV: st_reg <= ST_F_PIVW;
                ST_F_PIVW: begin
                    if (div_done) begin
                        cur_piv_reg           <= piv_sat;
                        piv_mem[IdxW'(i_reg)] <= piv_sat;
                        st_reg                <= ST_F_RHS2;
                    end
                end
                ST_F_RHS2: st_reg <= ST_F_RHS2W;
                ST_F_RHS2W: begin
                    if (div_done) begin
                        rhs_mem[IdxW'(i_reg)] <= q_sat;
                        prev_rhs_reg          <= q_sat;
                        prev_piv_reg          <= cur_piv_reg;
                        if (is_last_row) begin
                            st_reg <= ST_B_INIT;
                        end else begin
                            i_reg  <= i_reg + 1'b1;
                            st_reg <= ST_F_PIV;
                        end
                    end
                end
                ST_B_INIT: begin
                    x_reg <= prev_rhs_reg;
                    sol_mem[IdxW'(n_reg - 1'b1)] <= prev_rhs_reg;
                    if (n_reg == CntW'(1)) begin
                        i_reg  <= '0;
                        st_reg <= ST_O_OUT;
                    end else begin
                        i_reg  <= n_reg - 1'b1;
                        st_reg <= ST_B_DIV;
                    end
                end
                ST_B_DIV: st_reg <= ST_B_DIVW;
                ST_B_DIVW: begin
                    if (div_done) begin
                        x_reg <= back_val;
                        sol_mem[IdxW'(i_reg - 1'b1)] <= back_val;
                        if (i_reg == CntW'(1)) begin
                            i_reg  <= '0;
                            st_reg <= ST_O_OUT;
                        end else begin
                            i_reg  <= i_reg - 1'b1;
                            st_reg <= ST_B_DIV;
                        end
                    end
                end
                ST_O_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        if (is_last_row) st_reg <= ST_IDLE;
                        else i_reg <= i_reg + 1'b1;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
            // Emit one beat per node, drop it once taken
            if (st_reg == ST_O_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                m_index_reg <= 5'(i_reg + 1'b1);
                m_temp_reg  <= sol_mem[IdxW'(i_reg)];
                m_last_reg  <= is_last_row;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_index = m_index_reg;
    assign m_temp  = m_temp_reg;
    assign m_last  = m_last_reg;
endmodule
`default_nettype wire

[rtl/rod_conduction_tdma_solver_unit.sv]
// Top level of the rod conduction tridiagonal solver.
// Each request takes 2n-1 forward divides and n-1 back divides.
// One request at a time in the solver; a two-entry queue takes requests while a solve runs.
// Reset: synchronous active-low aresetn clears queue and sequencer; stores are not cleared.
`default_nettype none
module rod_conduction_tdma_solver_unit #(
    parameter int unsigned MAX_NODES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // left_temp[31:0], right_temp[63:32], node_count[68:64]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // node_index[4:0], node_temp[36:5]
    output logic             m_tlast
);
    rctdma_pkg::req_t in_req, q_req;
    logic q_valid, q_ready;
    logic [4:0] idx;
    logic signed [31:0] temp;

    assign in_req.left_temp  = s_tdata[31:0];
    assign in_req.right_temp = s_tdata[63:32];
    assign in_req.node_count = s_tdata[68:64];

    rctdma_front #(.MAX_NODES(MAX_NODES)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    rctdma_back #(.MAX_NODES(MAX_NODES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_req(q_req), .m_valid(m_tvalid), .m_ready(m_tready), .m_index(idx),
        .m_temp(temp), .m_last(m_tlast)
    );

    assign m_tdata = {3'b000, temp, idx};
endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the rod conduction tridiagonal solver.
`timescale 1ns / 1ps

module tb;
    localparam int unsigned NodeMax   = 16;
    localparam longint      FixOne    = 65536;
    localparam longint      CycleCap  = 64'd6_000_000;
    localparam int unsigned RandItems = 393;

    typedef struct {
        logic [4:0]         idx;
        logic signed [31:0] temp;
        logic               last;
    } node_beat_t;

    typedef struct {
        logic signed [31:0] left_t;
        logic signed [31:0] right_t;
        logic [4:0]         cnt;
        bit                 typed;
        logic signed [31:0] temp_typed;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // left_temp, right_temp, node_count, zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // node_index, node_temp, zero fill
    logic        m_tlast;

    node_beat_t  node_q[$];
    int unsigned fail_cnt;
    int unsigned req_cnt;
    int unsigned beat_cnt;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    longint      cycle_cnt;

    rod_conduction_tdma_solver_unit #(.MAX_NODES(NodeMax)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Free-running clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Clamp to the signed 32-bit range
    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 quotient, truncated toward zero
    function automatic longint fx_quot(input longint num, input longint den);
        if (den <= 0) begin
            return 0;
        end
        return (num * FixOne) / den;
    endfunction

    // Solve the rod system and queue one beat per node
    function automatic void solve_rod(input logic signed [31:0] ua,
                                      input logic signed [31:0] ub,
                                      input logic [4:0] cnt);
        longint piv[NodeMax];
        longint rhs[NodeMax];
        longint sol[NodeMax];
        longint diag;
        longint dv;
        int     n;
        node_beat_t b;
        n = cnt;
        if (n == 0) begin
            return;
        end
        if (n > NodeMax) begin
            n = NodeMax;
        end
        // forward sweep
        piv[0] = 3 * FixOne;
        rhs[0] = clip32(fx_quot((n == 1) ? 2 * longint'(ub) : 2 * longint'(ua), piv[0]));
        for (int i = 1; i < n; i++) begin
            diag   = (i == n - 1) ? 3 * FixOne : 2 * FixOne;
            dv     = (i == n - 1) ? 2 * longint'(ub) : 0;
            piv[i] = clip32(diag - fx_quot(FixOne, piv[i-1]));
            rhs[i] = clip32(fx_quot(dv + rhs[i-1], piv[i]));
        end
        // back substitution
        sol[n-1] = rhs[n-1];
        for (int i = n - 1; i >= 1; i--) begin
            sol[i-1] = clip32(rhs[i-1] + fx_quot(sol[i], piv[i-1]));
        end
        for (int i = 0; i < n; i++) begin
            b.idx  = 5'(i + 1);
            b.temp = 32'(sol[i]);
            b.last = (i == n - 1);
            node_q.push_back(b);
        end
    endfunction

    // Offer one request; predict its nodes once the beat is taken
    task automatic send_req(input stim_row_t r);
        node_beat_t b;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {3'b000, r.cnt, r.right_t, r.left_t};
        s_tvalid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        req_cnt++;
        if (r.typed) begin
            b.idx  = 5'd1;
            b.temp = r.temp_typed;
            b.last = 1'b1;
            node_q.push_back(b);
        end else begin
            solve_rod(r.left_t, r.right_t, r.cnt);
        end
        @(negedge aclk);
    endtask

    // Random result stalls, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each node beat against the oldest expectation
    always @(posedge aclk) begin
        node_beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beat_cnt++;
            if (node_q.size() == 0) begin
                $error("unexpected beat: node_index %0d node_temp %0h",
                       m_tdata[4:0], m_tdata[36:5]);
                fail_cnt++;
            end else begin
                e = node_q.pop_front();
                if (m_tdata[4:0] !== e.idx) begin
                    $error("node_index expected %0d actual %0d", e.idx, m_tdata[4:0]);
                    fail_cnt++;
                end
                if (m_tdata[36:5] !== e.temp) begin
                    $error("node_temp expected %0h actual %0h", e.temp, m_tdata[36:5]);
                    fail_cnt++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_node expected %0b actual %0b", e.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleCap) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        stim_row_t dir_tbl[$];
        stim_row_t r;
        int unsigned ph;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        req_cnt        = 0;

        // single node uses the right end only: result is 2*right/3
        dir_tbl.push_back('{32'sh0005_0000, 32'sh0003_0000, 5'd1, 1'b1, 32'sh0002_0000});
        dir_tbl.push_back('{32'sh7FFF_FFFF, 32'sh0000_0000, 5'd1, 1'b1, 32'sh0000_0000});
        dir_tbl.push_back('{32'sh0000_0000, 32'shFFFD_0000, 5'd1, 1'b1, 32'shFFFE_0000});
        dir_tbl.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd1, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh8000_0000, 32'sh8000_0000, 5'd1, 1'b0, 32'sh0});
        // zero nodes: nothing comes back
        dir_tbl.push_back('{32'sh0001_0000, 32'sh0002_0000, 5'd0, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh0064_0000, 32'sh0000_0000, 5'd2, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh0000_0000, 32'sh0064_0000, 5'd3, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh0064_0000, 32'sh01F4_0000, 5'd5, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 5'd2, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 5'd16, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd16, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh8000_0000, 32'sh8000_0000, 5'd15, 1'b0, 32'sh0});
        // counts above the store depth saturate
        dir_tbl.push_back('{32'sh0010_0000, 32'shFFF0_0000, 5'd17, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'shFFFF_FFFF, 32'sh0000_0001, 5'd31, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'sh0000_0000, 32'sh0000_0000, 5'd0, 1'b0, 32'sh0});
        dir_tbl.push_back('{32'shFFFF_FFFF, 32'shFFFF_FFFF, 5'd8, 1'b0, 32'sh0});

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table, no idling
        foreach (dir_tbl[k]) begin
            send_req(dir_tbl[k]);
        end

        // random requests across the idling phases
        for (int i = 0; i < RandItems; i++) begin
            ph = i * 5 / RandItems;
            send_idle_pct  = (ph == 1) ? 73 : (ph == 4) ? 8 : 0;
            recv_stall_pct = (ph == 2) ? 73 : (ph == 4) ? 8 : 0;
            // hold off until the pipe drains once
            if (i == RandItems / 2) begin
                s_tvalid = 1'b0;
                while (node_q.size() != 0) @(negedge aclk);
            end
            if ($urandom_range(9) < 7) begin
                r.cnt = 5'($urandom_range(4, 1));
            end else begin
                r.cnt = 5'($urandom_range(31, 0));
            end
            if ($urandom_range(1)) begin
                r.left_t  = $signed(32'($urandom));
                r.right_t = $signed(32'($urandom));
            end else begin
                r.left_t  = $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
                r.right_t = $signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000;
            end
            r.typed      = 1'b0;
            r.temp_typed = '0;
            send_req(r);
        end
        s_tvalid = 1'b0;
        recv_stall_pct = 0;

        // drain, then allow a full solve time for strays
        while (node_q.size() != 0) @(posedge aclk);
        repeat (4200) @(posedge aclk);

        $display("Covered %0d requests (node counts 0..31, extreme temps) and %0d node beats,",
                 req_cnt, beat_cnt);
        $display("under free-running, sender-idle, receiver-stall and mixed pacing.");
        if (fail_cnt == 0 && node_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[files.f]
rtl/rctdma_pkg.sv
rtl/rctdma_divider.sv
rtl/rctdma_front.sv
rtl/rctdma_back.sv
rtl/rod_conduction_tdma_solver_unit.sv
dv/tb.sv
